// ===== rtl/vector_normalize_3d_defines.svh =====
// Assertion macros shared by the vector normalizer RTL.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef VECTOR_NORMALIZE_3D_DEFINES_SVH
`define VECTOR_NORMALIZE_3D_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VN3D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define VN3D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/vn3d_pkg.sv =====
// Shared constants for the vector normalizer.
// No dependencies.
package vn3d_pkg;

  // Output word widths and the fixed-point format of the unit vector.
  localparam int OUT_W     = 16;
  localparam int UNIT_FRAC = 14;

  // Quotient of sq / sum scaled by 2^(2*UNIT_FRAC): one integer bit plus fraction.
  localparam int QUO_W     = 2 * UNIT_FRAC + 1;

  // Root of that quotient.
  localparam int UROOT_W   = UNIT_FRAC + 1;

  // Largest length that fits the output word.
  localparam logic [OUT_W-1:0] LEN_MAX = '1;

endpackage

// ===== rtl/vn3d_div_cell.sv =====
// One restoring-division step: compares, subtracts and shifts one quotient bit in.
// No dependencies; chained by the top level.
module vn3d_div_cell #(
  parameter int W  = 32,
  parameter int QW = 29
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W:0]    cur_in,
  input  logic [W-1:0]  den_in,
  input  logic [QW-1:0] q_in,
  output logic [W-1:0]  rem_out,
  output logic [W-1:0]  den_out,
  output logic [QW-1:0] q_out
);

  logic          take;
  logic [W:0]    diff;

  // Trial subtraction against the divisor.
  assign take = (cur_in >= {1'b0, den_in});
  assign diff = cur_in - {1'b0, den_in};

  // The remainder always stays below the divisor, so W bits hold it.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? diff[W-1:0] : cur_in[W-1:0];
      den_out <= den_in;
      q_out   <= {q_in[QW-2:0], take};
    end
  end

endmodule

// ===== rtl/vn3d_sqrt_cell.sv =====
// One digit of a restoring integer square root: two radicand bits in, one root bit out.
// No dependencies; chained by the top level.
module vn3d_sqrt_cell #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] v_in,
  input  logic [N:0]     rem_in,
  input  logic [N-1:0]   root_in,
  output logic [2*N-1:0] v_out,
  output logic [N:0]     rem_out,
  output logic [N-1:0]   root_out
);

  logic [N+2:0] cur;
  logic [N+2:0] trial;
  logic         take;
  logic [N+2:0] diff;

  // Bring down the next two radicand bits and test root*4+1.
  assign cur   = {rem_in, v_in[2*N-1 -: 2]};
  assign trial = {1'b0, root_in, 2'b01};
  assign take  = (cur >= trial);
  assign diff  = cur - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      v_out    <= {v_in[2*N-3:0], 2'b00};
      rem_out  <= take ? diff[N:0] : cur[N:0];
      root_out <= {root_in[N-2:0], take};
    end
  end

endmodule

// ===== rtl/vn3d_delay.sv =====
// Enabled shift line that carries side data alongside the arithmetic chains.
// No dependencies.
module vn3d_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  // Each tap takes its neighbor's word whenever the pipeline moves.
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ===== rtl/vector_normalize_3d.sv =====
// Vector normalizer: accepts one signed Q8.8 3-vector per clock and returns its length
// (unsigned Q8.8, saturated at 0xFFFF) and unit vector (signed Q1.14, each component
// floor(sqrt(c^2 * 2^28 / sum)) with the input's sign), or a zero-vector flag with zero
// fields. Throughput is one word per cycle while the output is not held; the pipeline is the
// squaring and summing stages, the 29-cell division chain followed by the 15-cell root chain
// and an output register, with a parallel COMP_BITS-cell chain for the length. The whole
// pipeline stalls together when the output is held, so nothing is lost.
module vector_normalize_3d #(
  parameter int COMP_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COMP_BITS-1:0] comp_x,
  input  logic signed [COMP_BITS-1:0] comp_y,
  input  logic signed [COMP_BITS-1:0] comp_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vn3d_pkg::OUT_W-1:0]  length,
  output logic signed [vn3d_pkg::OUT_W-1:0] unit_x,
  output logic signed [vn3d_pkg::OUT_W-1:0] unit_y,
  output logic signed [vn3d_pkg::OUT_W-1:0] unit_z,
  output logic                        zero_vector
);
  import vn3d_pkg::*;
  `include "vector_normalize_3d_defines.svh"

  localparam int SQ_W    = 2 * COMP_BITS;
  localparam int CHAIN   = QUO_W + UROOT_W;
  localparam int LEN_PAD = CHAIN - COMP_BITS;
  localparam int DEPTH   = CHAIN + 3;
  localparam int LW      = COMP_BITS + OUT_W;

  logic             adv;
  logic [DEPTH-1:0] vld;

  // Whole pipeline advances unless a finished word is being held.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Stage 1: magnitudes squared and signs.
  logic [COMP_BITS-1:0] mag [3];
  logic [SQ_W-1:0]      sq1 [3];
  logic [2:0]           neg1;
  logic [COMP_BITS-1:0] comp [3];

  assign comp[0] = comp_x;
  assign comp[1] = comp_y;
  assign comp[2] = comp_z;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = comp[l][COMP_BITS-1] ? (~comp[l] + 1'b1) : comp[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        sq1[l]  <= SQ_W'(mag[l]) * SQ_W'(mag[l]);
        neg1[l] <= comp[l][COMP_BITS-1];
      end
    end
  end

  // Stage 2: sum of squares and the zero test.
  logic [SQ_W-1:0] sq2 [3];
  logic [SQ_W-1:0] sum2;
  logic [2:0]      neg2;
  logic            zero2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        sq2[l] <= sq1[l];
      end
      sum2  <= sq1[0] + sq1[1] + sq1[2];
      neg2  <= neg1;
      zero2 <= (sq1[0] == '0) && (sq1[1] == '0) && (sq1[2] == '0);
    end
  end

  // Division chains: floor(sq * 2^28 / sum), one quotient bit per cell.
  logic [SQ_W-1:0]  d_rem [3][QUO_W];
  logic [SQ_W-1:0]  d_den [3][QUO_W];
  logic [QUO_W-1:0] d_q   [3][QUO_W];

  // Root chains on the quotients, one root bit per cell.
  logic [2*UROOT_W-1:0] u_v    [3][UROOT_W];
  logic [UROOT_W:0]     u_rem  [3][UROOT_W];
  logic [UROOT_W-1:0]   u_root [3][UROOT_W];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
      if (k == 0) begin : g_first
        vn3d_div_cell #(.W(SQ_W), .QW(QUO_W)) u_cell (
          .clk(clk), .en(adv),
          .cur_in({1'b0, sq2[l]}), .den_in(sum2), .q_in('0),
          .rem_out(d_rem[l][k]), .den_out(d_den[l][k]), .q_out(d_q[l][k])
        );
      end else begin : g_next
        vn3d_div_cell #(.W(SQ_W), .QW(QUO_W)) u_cell (
          .clk(clk), .en(adv),
          .cur_in({d_rem[l][k-1], 1'b0}), .den_in(d_den[l][k-1]), .q_in(d_q[l][k-1]),
          .rem_out(d_rem[l][k]), .den_out(d_den[l][k]), .q_out(d_q[l][k])
        );
      end
    end
    for (genvar k = 0; k < UROOT_W; k++) begin : g_root
      if (k == 0) begin : g_first
        vn3d_sqrt_cell #(.N(UROOT_W)) u_cell (
          .clk(clk), .en(adv),
          .v_in((2*UROOT_W)'(d_q[l][QUO_W-1])), .rem_in('0), .root_in('0),
          .v_out(u_v[l][k]), .rem_out(u_rem[l][k]), .root_out(u_root[l][k])
        );
      end else begin : g_next
        vn3d_sqrt_cell #(.N(UROOT_W)) u_cell (
          .clk(clk), .en(adv),
          .v_in(u_v[l][k-1]), .rem_in(u_rem[l][k-1]), .root_in(u_root[l][k-1]),
          .v_out(u_v[l][k]), .rem_out(u_rem[l][k]), .root_out(u_root[l][k])
        );
      end
    end
  end

  // Length root chain runs beside the division, then waits in a shift line.
  logic [SQ_W-1:0]      l_v    [COMP_BITS];
  logic [COMP_BITS:0]   l_rem  [COMP_BITS];
  logic [COMP_BITS-1:0] l_root [COMP_BITS];
  logic [COMP_BITS-1:0] len_d;

  for (genvar k = 0; k < COMP_BITS; k++) begin : g_len
    if (k == 0) begin : g_first
      vn3d_sqrt_cell #(.N(COMP_BITS)) u_cell (
        .clk(clk), .en(adv),
        .v_in(sum2), .rem_in('0), .root_in('0),
        .v_out(l_v[k]), .rem_out(l_rem[k]), .root_out(l_root[k])
      );
    end else begin : g_next
      vn3d_sqrt_cell #(.N(COMP_BITS)) u_cell (
        .clk(clk), .en(adv),
        .v_in(l_v[k-1]), .rem_in(l_rem[k-1]), .root_in(l_root[k-1]),
        .v_out(l_v[k]), .rem_out(l_rem[k]), .root_out(l_root[k])
      );
    end
  end

  vn3d_delay #(.W(COMP_BITS), .DEPTH(LEN_PAD)) u_len_delay (
    .clk(clk), .en(adv), .d(l_root[COMP_BITS-1]), .q(len_d)
  );

  // Signs and the zero flag travel alongside the chains.
  logic [3:0] side_d;

  vn3d_delay #(.W(4), .DEPTH(CHAIN)) u_side_delay (
    .clk(clk), .en(adv), .d({zero2, neg2}), .q(side_d)
  );

  // Output register: saturate the length, apply signs, clear a zero vector.
  logic [UROOT_W-1:0] uroot [3];
  logic [OUT_W-1:0]   unit_n [3];
  logic               len_sat;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      uroot[l]  = u_root[l][UROOT_W-1];
      unit_n[l] = side_d[l] ? (OUT_W'(~{1'b0, uroot[l]}) + 1'b1) : OUT_W'(uroot[l]);
    end
    len_sat = (LW'(len_d) > LW'(LEN_MAX));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_vector <= side_d[3];
      length      <= side_d[3] ? '0 : (len_sat ? LEN_MAX : OUT_W'(len_d));
      unit_x      <= side_d[3] ? '0 : unit_n[0];
      unit_y      <= side_d[3] ? '0 : unit_n[1];
      unit_z      <= side_d[3] ? '0 : unit_n[2];
    end
  end

  // A zero vector yields all-zero fields; anything else has a nonzero length.
  `VN3D_ASSERT_IMP(a_zero_fields, out_valid && zero_vector, length == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0, "zero vector with nonzero fields")
  `VN3D_ASSERT_IMP(a_len_nonzero, out_valid && !zero_vector, length != '0, "nonzero vector with zero length")
  `VN3D_ASSERT_IMP(a_unit_range, out_valid, unit_x <= 16'sd16384 && unit_x >= -16'sd16384 && unit_y <= 16'sd16384 && unit_y >= -16'sd16384 && unit_z <= 16'sd16384 && unit_z >= -16'sd16384, "unit component out of range")
  `VN3D_ASSERT_NXT(a_drain, out_valid && out_ready && !vld[DEPTH-2], !out_valid, "output word repeated")

endmodule
